// ===== hw/rtl/sps_pkg.sv =====
// Shared types and constants for the successor position search block.
// Holds table sizing, request codes and the request/response transaction structs.
// No dependencies.
package sps_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int KEY_WIDTH   = 16;

  localparam int POS_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int REQ_W       = 2;
  localparam int KEY_FIELD_W = 16;
  localparam int POS_FIELD_W = 9;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]       req_type;
    logic [KEY_FIELD_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [POS_FIELD_W-1:0] target_position;
    logic                   wrapped;
    logic [POS_FIELD_W-1:0] lowest_position;
    logic                   table_empty;
  } rsp_t;

endpackage

// ===== hw/rtl/sps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/successor_position_search.sv =====
// Successor position search: ordered key table with successor and minimum lookup.
// Clear and append transactions keep busy low and give no result.
// A query keeps busy high while it issues one RAM read per loaded entry (ST_SCAN), then
// waits for the last read data (ST_WAIT); done pulses on the cycle after that.
// A query on an empty table answers on the next cycle without going busy. Results cannot stall.
// Synchronous active-high reset empties the table (entry count to zero); no clearing pass.
module successor_position_search (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sps_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output sps_pkg::rsp_t rsp
);
  import sps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  state_t state;

  // Entry count and scan address
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] addr;
  logic             last_issue;

  // Read return tracking: data on rdata belongs to rd_pos when rd_valid
  logic             rd_valid;
  logic [POS_W-1:0] rd_pos;
  logic [KEY_WIDTH-1:0] rdata;

  // Running minimum and successor of the current query
  logic [KEY_WIDTH-1:0] qkey;
  logic [KEY_WIDTH-1:0] low_key, low_key_next;
  logic [POS_W-1:0]     low_pos, low_pos_next;
  logic [KEY_WIDTH-1:0] succ_key, succ_key_next;
  logic [POS_W-1:0]     succ_pos, succ_pos_next;
  logic                 have_succ, have_succ_next;

  // Transaction accept and RAM write and read enables
  logic accept;
  logic wr_en;
  logic rd_en;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Append writes straight into the next free slot; drop it once the table is full.
  assign wr_en = accept && (req.req_type == REQ_APPEND) && (cnt < CNT_W'(TABLE_DEPTH));
  assign rd_en = (state == ST_SCAN);

  assign last_issue = (CNT_W'(addr) == (cnt - CNT_W'(1)));

  sps_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_key_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(cnt[POS_W-1:0]),
    .wdata(req.key[KEY_WIDTH-1:0]),
    .re   (rd_en),
    .raddr(addr),
    .rdata(rdata)
  );

  // Fold one returned entry into the running minimum and successor.
  // Strict compares keep the first position on equal keys.
  always_comb begin
    low_key_next   = low_key;
    low_pos_next   = low_pos;
    succ_key_next  = succ_key;
    succ_pos_next  = succ_pos;
    have_succ_next = have_succ;
    if (rd_valid) begin
      if ((rd_pos == '0) || (rdata < low_key)) begin
        low_key_next = rdata;
        low_pos_next = rd_pos;
      end
      if ((rdata > qkey) && (!have_succ || (rdata < succ_key))) begin
        succ_key_next  = rdata;
        succ_pos_next  = rd_pos;
        have_succ_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      // Defaults: drop the strobe, advance the running values
      done      <= 1'b0;
      rd_valid  <= 1'b0;
      low_key   <= low_key_next;
      low_pos   <= low_pos_next;
      succ_key  <= succ_key_next;
      succ_pos  <= succ_pos_next;
      have_succ <= have_succ_next;

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            case (req.req_type)
              REQ_CLEAR: begin
                cnt <= '0;
              end
              REQ_APPEND: begin
                if (cnt < CNT_W'(TABLE_DEPTH)) begin
                  cnt <= cnt + CNT_W'(1);
                end
              end
              REQ_QUERY: begin
                qkey      <= req.key[KEY_WIDTH-1:0];
                have_succ <= 1'b0;
                if (cnt == '0) begin
                  // Empty table: answer at once with all positions zero
                  done                <= 1'b1;
                  rsp.target_position <= '0;
                  rsp.wrapped         <= 1'b0;
                  rsp.lowest_position <= '0;
                  rsp.table_empty     <= 1'b1;
                end else begin
                  addr  <= '0;
                  state <= ST_SCAN;
                end
              end
              default: begin
                // Unused request code: ignore
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle over the loaded entries
          rd_valid <= 1'b1;
          rd_pos   <= addr;
          addr     <= addr + POS_W'(1);
          if (last_issue) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // Last entry is on rdata: publish the folded result
          done                <= 1'b1;
          rsp.target_position <= POS_FIELD_W'(have_succ_next ? succ_pos_next : low_pos_next);
          rsp.wrapped         <= !have_succ_next;
          rsp.lowest_position <= POS_FIELD_W'(low_pos_next);
          rsp.table_empty     <= 1'b0;
          state               <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A scan only runs over a non-empty table
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt != '0))
    else $error("scan running with empty table");

  // The wait state always produces a result strobe
  a_wait_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |=> done)
    else $error("query finished without result");

  // A wrapped answer points at the smallest key
  a_wrap_low: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.wrapped) |-> (rsp.target_position == rsp.lowest_position))
    else $error("wrapped target differs from lowest position");

  // An empty-table answer carries zero positions and no wrap
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.table_empty) |->
      ((rsp.target_position == '0) && !rsp.wrapped && (rsp.lowest_position == '0)))
    else $error("empty-table answer not zeroed");

  // Writes stay inside the table
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cnt < CNT_W'(TABLE_DEPTH)))
    else $error("append written past table depth");

endmodule

// ===== tb/successor_position_search_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for successor_position_search: a queue-fed driver, a monitor
// with its own table model, and a watchdog. Depends on sps_pkg and the block's RTL.
module successor_position_search_tb;
  import sps_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 1170;
  // The longest silent stretch is a query over a full table
  // plus a long random sender gap; allow several times that.
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    req_t item;
    bit   drain_first;  // hold this transaction until every answer has come back
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  pending_t pending_requests[$];
  rsp_t     expected_answers[$];

  // Model of the block's table.
  logic [KEY_WIDTH-1:0] key_store [TABLE_DEPTH];
  int unsigned          stored_count;

  bit took_item;       // set at the rising edge that accepted a transaction
  int items_sent;
  int phase1_end;
  int phase2_end;
  int quiet_cycles;
  int mismatches;

  successor_position_search u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  initial forever #5 clk = ~clk;

  function automatic void queue_request(logic [REQ_W-1:0] kind, logic [KEY_FIELD_W-1:0] k,
                                        bit drain = 1'b0);
    pending_t p;
    p.item.req_type = kind;
    p.item.key      = k;
    p.drain_first   = drain;
    pending_requests.push_back(p);
  endfunction

  // Advance the table model by one accepted transaction; queue an answer for a query.
  function automatic void predict_request(req_t r);
    rsp_t                 ans;
    logic [KEY_WIDTH-1:0] k;
    logic [KEY_WIDTH-1:0] v;
    logic [KEY_WIDTH-1:0] succ_key;
    logic [KEY_WIDTH-1:0] min_key;
    bit                   have_succ;
    int unsigned          succ_pos;
    int unsigned          min_pos;
    k         = r.key[KEY_WIDTH-1:0];
    ans       = '0;
    have_succ = 1'b0;
    succ_key  = '0;
    min_key   = '0;
    succ_pos  = 0;
    min_pos   = 0;
    case (r.req_type)
      REQ_CLEAR: begin
        stored_count = 0;
      end
      REQ_APPEND: begin
        // drop the append once the table is full
        if (stored_count < TABLE_DEPTH) begin
          key_store[stored_count] = k;
          stored_count++;
        end
      end
      REQ_QUERY: begin
        if (stored_count == 0) begin
          ans.table_empty = 1'b1;
        end else begin
          // strict compares keep the first position on ties
          for (int unsigned i = 0; i < stored_count; i++) begin
            v = key_store[i];
            if (i == 0 || v < min_key) begin
              min_key = v;
              min_pos = i;
            end
            if (v > k && (!have_succ || v < succ_key)) begin
              have_succ = 1'b1;
              succ_key  = v;
              succ_pos  = i;
            end
          end
          ans.target_position = POS_FIELD_W'(have_succ ? succ_pos : min_pos);
          ans.wrapped         = !have_succ;
          ans.lowest_position = POS_FIELD_W'(min_pos);
        end
        expected_answers.push_back(ans);
      end
      default: ;  // unused code: ignored
    endcase
  endfunction

  function automatic void compare_field(string name, logic [POS_FIELD_W-1:0] want,
                                        logic [POS_FIELD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: change inputs at the falling edge. Hold a transaction until it is taken,
  // then idle at random or present the next one.
  always @(negedge clk) begin
    pending_t next_item;
    int       idle_pct;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      idle_pct = (items_sent < phase1_end) ? 32 : (items_sent < phase2_end) ? 58 : 0;
      if (pending_requests.size() == 0 ||
          (pending_requests[0].drain_first && expected_answers.size() != 0) ||
          $urandom_range(99) < idle_pct) begin
        start <= 1'b0;
      end else begin
        next_item = pending_requests.pop_front();
        req       <= next_item.item;
        start     <= 1'b1;
        items_sent++;
      end
    end
  end

  // Monitor: sample at the rising edge. Check results first so that an answer
  // never meets an expectation queued at the same edge.
  always @(posedge clk) begin
    rsp_t want;
    took_item = 1'b0;
    if (rst) begin
      stored_count = 0;
      quiet_cycles = 0;
    end else begin
      if (done === 1'b1) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: result with none expected: expected nothing, got %p", $time, rsp);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          compare_field("target_position", want.target_position, rsp.target_position);
          compare_field("wrapped", POS_FIELD_W'(want.wrapped), POS_FIELD_W'(rsp.wrapped));
          compare_field("lowest_position", want.lowest_position, rsp.lowest_position);
          compare_field("table_empty", POS_FIELD_W'(want.table_empty),
                        POS_FIELD_W'(rsp.table_empty));
        end
      end
      if (start && busy === 1'b0) begin
        took_item = 1'b1;
        predict_request(req);
      end
      if (took_item || done === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog: no transaction for %0d cycles", $time, quiet_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_FIELD_W-1:0] seq_keys[$];
    logic [KEY_FIELD_W-1:0] k;
    bit                     filled;
    bit                     narrow;
    int                     shape;
    int                     n;
    int                     pick;
    filled = 1'b0;

    // Directed: empty table, ignored code, extreme keys, ties, wrap, clear.
    queue_request(REQ_QUERY, 16'h0000);
    queue_request(REQ_UNUSED, 16'hFFFF);
    queue_request(REQ_APPEND, 16'h8000);
    queue_request(REQ_APPEND, 16'hFFFF);
    queue_request(REQ_APPEND, 16'h0000);
    queue_request(REQ_APPEND, 16'h0000);  // tie on the minimum: first position wins
    queue_request(REQ_APPEND, 16'h8000);  // tie on a successor
    queue_request(REQ_QUERY, 16'h0000);
    queue_request(REQ_QUERY, 16'h7FFF);
    queue_request(REQ_QUERY, 16'h8000);
    queue_request(REQ_QUERY, 16'hFFFF);   // nothing above: wrap to the minimum
    queue_request(REQ_QUERY, 16'hFFFE);
    queue_request(REQ_UNUSED, 16'h1234);
    queue_request(REQ_CLEAR, 16'h0000, 1'b1);
    queue_request(REQ_QUERY, 16'hFFFF);
    queue_request(REQ_APPEND, 16'h5555);
    queue_request(REQ_QUERY, 16'h5555);   // equal key is not a successor
    queue_request(REQ_QUERY, 16'h0000);
    queue_request(REQ_APPEND, 16'hAAAA);
    queue_request(REQ_QUERY, 16'h5555);
    queue_request(REQ_CLEAR, 16'hFFFF);
    queue_request(REQ_QUERY, 16'h0000);

    // Random: mostly clear / load / query sequences, some noise, one full table.
    while (pending_requests.size() < ITEM_TARGET) begin
      if (!filled && pending_requests.size() >= 400) begin
        // Fill every position; the unique minimum sits in the last one so that
        // the top position bit shows up in both position fields.
        filled = 1'b1;
        queue_request(REQ_CLEAR, KEY_FIELD_W'($urandom), 1'b1);
        repeat (TABLE_DEPTH - 1)
          queue_request(REQ_APPEND, KEY_FIELD_W'($urandom_range(16'hFFFE, 1)));
        queue_request(REQ_APPEND, 16'h0000);
        queue_request(REQ_APPEND, 16'h0000);  // dropped: table full
        queue_request(REQ_APPEND, KEY_FIELD_W'($urandom));
        queue_request(REQ_QUERY, 16'hFFFF);
        queue_request(REQ_QUERY, 16'h0000);
        repeat (8) queue_request(REQ_QUERY, KEY_FIELD_W'($urandom));
        continue;
      end
      shape = $urandom_range(99);
      if (shape < 8) begin
        repeat ($urandom_range(1, 3)) queue_request(REQ_UNUSED, KEY_FIELD_W'($urandom));
      end else if (shape < 14) begin
        queue_request(REQ_CLEAR, KEY_FIELD_W'($urandom));
        queue_request(REQ_QUERY, KEY_FIELD_W'($urandom));
      end else if (shape < 20) begin
        // broken sequence: queries and appends with no clear in front
        repeat ($urandom_range(1, 4))
          queue_request($urandom_range(1) ? REQ_QUERY : REQ_APPEND, KEY_FIELD_W'($urandom));
      end else begin
        narrow = ($urandom_range(2) == 0);  // small key range gives many ties
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
        seq_keys.delete();
        if ($urandom_range(3) != 0)
          queue_request(REQ_CLEAR, KEY_FIELD_W'($urandom), $urandom_range(15) == 0);
        for (int i = 0; i < n; i++) begin
          k = narrow ? KEY_FIELD_W'($urandom_range(15)) : KEY_FIELD_W'($urandom);
          seq_keys.push_back(k);
          queue_request(REQ_APPEND, k);
          if ($urandom_range(7) == 0) queue_request(REQ_QUERY, KEY_FIELD_W'($urandom_range(16)));
        end
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(seq_keys.size() - 1);
          case ($urandom_range(5))
            0: k = 16'h0000;
            1: k = 16'hFFFF;
            2: k = seq_keys[pick];
            3: k = seq_keys[pick] + 1'b1;
            4: k = seq_keys[pick] - 1'b1;
            default: k = narrow ? KEY_FIELD_W'($urandom_range(16)) : KEY_FIELD_W'($urandom);
          endcase
          queue_request(REQ_QUERY, k);
        end
      end
    end

    // Random sender idle is 32% for the first third, 58% for the second, none after.
    phase1_end = pending_requests.size() / 3;
    phase2_end = 2 * pending_requests.size() / 3;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || start || expected_answers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sps_pkg.sv
hw/rtl/sps_ram.sv
hw/rtl/successor_position_search.sv
tb/successor_position_search_tb.sv
